@@ design/mfrf_pkg.sv @@
package mfrf_pkg;

    localparam int SEEN_DEPTH = 32;
    localparam int IDX_W      = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;

    localparam int ADDR_W = 48;
    localparam int ID_W   = 32;
    localparam int BYTE_W = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [31:0]       RAW_PING  = 32'h5049_4E47;
    localparam logic [31:0]       RAW_PONG  = 32'h504F_4E47;
    localparam logic [BYTE_W-1:0] RAW_LEN   = 8'd4;
    localparam logic [BYTE_W-1:0] APP_COORD = 8'hFF;
    localparam logic [BYTE_W-1:0] APP_NODE  = 8'h00;

    localparam logic [ADDR_W-1:0] RST_BCAST     = 48'hFFFF_FFFF_FFFF;
    localparam logic [BYTE_W-1:0] RST_CODE_DATA = 8'd1;
    localparam logic [BYTE_W-1:0] RST_CODE_PING = 8'd2;
    localparam logic [BYTE_W-1:0] RST_CODE_PONG = 8'd3;
    localparam logic [BYTE_W-1:0] RST_HDR_BYTES = 8'd220;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_ROLE   = 3'd0,
        CFG_OWN_ADDR    = 3'd1,
        CFG_BCAST_ADDR  = 3'd2,
        CFG_CODE_DATA   = 3'd3,
        CFG_CODE_PING   = 3'd4,
        CFG_CODE_PONG   = 3'd5,
        CFG_HDR_BYTES   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic is_mesh;
        logic scan_last;
        logic out_free;
    } t_status;

endpackage

@@ design/mfrf_ctrl.sv @@
module mfrf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  mfrf_pkg::t_status i_status,
    output mfrf_pkg::t_cmd   o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CLASS  = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_COMMIT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CLASS;
                end
            end
            S_CLASS: begin
                if (i_status.is_mesh) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            // last read compares here
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

@@ design/mfrf_dp.sv @@
module mfrf_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mfrf_pkg::t_cmd                 i_cmd,
    output mfrf_pkg::t_status              o_status,
    input  logic                           i_cfg_valid,
    input  logic [mfrf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mfrf_pkg::ADDR_W-1:0]    i_cfg_data,
    input  logic [mfrf_pkg::BYTE_W-1:0]    i_frame_len,
    input  logic [31:0]                    i_head_word,
    input  logic [mfrf_pkg::ADDR_W-1:0]    i_sender_address,
    input  logic [mfrf_pkg::ID_W-1:0]      i_msg_id,
    input  logic [mfrf_pkg::BYTE_W-1:0]    i_pkt_type,
    input  logic [mfrf_pkg::BYTE_W-1:0]    i_hop_limit,
    input  logic [mfrf_pkg::ADDR_W-1:0]    i_dest_address,
    input  logic [mfrf_pkg::ADDR_W-1:0]    i_origin_address,
    input  logic [mfrf_pkg::BYTE_W-1:0]    i_app_code,
    input  logic [mfrf_pkg::BYTE_W-1:0]    i_body_len,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_raw_pong_send,
    output logic                           o_reply_pong,
    output logic [mfrf_pkg::BYTE_W-1:0]    o_reply_app,
    output logic [mfrf_pkg::ADDR_W-1:0]    o_reply_dest,
    output logic [mfrf_pkg::BYTE_W-1:0]    o_reply_hops,
    output logic                           o_deliver,
    output logic                           o_relay,
    output logic [mfrf_pkg::BYTE_W-1:0]    o_relay_hops,
    output logic [mfrf_pkg::ADDR_W-1:0]    o_coord_address,
    output logic                           o_coord_known,
    output logic                           o_raw_pong_seen,
    output logic                           o_duplicate
);

    localparam int EW = mfrf_pkg::ID_W + mfrf_pkg::BYTE_W;

    // configuration
    logic                        r_role;
    logic [mfrf_pkg::ADDR_W-1:0] r_own;
    logic [mfrf_pkg::ADDR_W-1:0] r_bcast;
    logic [mfrf_pkg::BYTE_W-1:0] r_code_data;
    logic [mfrf_pkg::BYTE_W-1:0] r_code_ping;
    logic [mfrf_pkg::BYTE_W-1:0] r_code_pong;
    logic [mfrf_pkg::BYTE_W-1:0] r_hdr_bytes;

    // captured item
    logic [mfrf_pkg::BYTE_W-1:0] r_frame_len;
    logic [31:0]                 r_head_word;
    logic [mfrf_pkg::ADDR_W-1:0] r_sender;
    logic [mfrf_pkg::ID_W-1:0]   r_msg_id;
    logic [mfrf_pkg::BYTE_W-1:0] r_pkt_type;
    logic [mfrf_pkg::BYTE_W-1:0] r_hop_limit;
    logic [mfrf_pkg::ADDR_W-1:0] r_dest;
    logic [mfrf_pkg::ADDR_W-1:0] r_origin;
    logic [mfrf_pkg::BYTE_W-1:0] r_app_code;
    logic [mfrf_pkg::BYTE_W-1:0] r_body_len;

    // seen ring
    logic [EW-1:0]                  r_mem [mfrf_pkg::SEEN_DEPTH];
    logic [mfrf_pkg::SEEN_DEPTH-1:0] r_vld;
    logic [mfrf_pkg::IDX_W-1:0]     r_ptr;
    logic [mfrf_pkg::IDX_W-1:0]     r_cnt;
    logic [EW-1:0]                  r_rd_data;
    logic                           r_rd_vld;
    logic                           r_rd_live;
    logic                           r_hit;

    // persistent state
    logic [mfrf_pkg::ADDR_W-1:0] r_coord_addr;
    logic                        r_coord_known;
    logic                        r_pong_flag;
    logic                        r_out_valid;

    logic                        raw_ping;
    logic                        raw_pong;
    logic                        is_mesh;
    logic                        fresh;
    logic                        match;
    logic                        to_me;
    logic                        for_me;
    logic                        terminal;
    logic                        is_ping;
    logic                        learn;
    logic                        do_relay;
    logic                        ring_wr;
    logic [mfrf_pkg::ADDR_W-1:0] n_coord_addr;
    logic                        n_coord_known;
    logic                        n_pong_flag;
    logic [mfrf_pkg::IDX_W-1:0]  ptr_inc;
    logic [mfrf_pkg::IDX_W-1:0]  cnt_inc;
    logic                        scan_last;

    assign raw_ping = (r_frame_len == mfrf_pkg::RAW_LEN) && (r_head_word == mfrf_pkg::RAW_PING);
    assign raw_pong = (r_frame_len == mfrf_pkg::RAW_LEN) && (r_head_word == mfrf_pkg::RAW_PONG);
    assign is_mesh  = !raw_ping && !raw_pong && (r_frame_len >= r_hdr_bytes);
    assign fresh    = is_mesh && !r_hit;

    assign match = r_rd_live && r_rd_vld && (r_rd_data == {r_msg_id, r_pkt_type});

    assign to_me    = (r_dest == r_own);
    assign for_me   = to_me || (r_dest == r_bcast);
    assign terminal = (r_pkt_type == r_code_data) && to_me;
    assign is_ping  = (r_pkt_type == r_code_ping);
    assign learn    = fresh && !r_role && (r_pkt_type == r_code_pong)
                      && (r_app_code == mfrf_pkg::APP_COORD);
    assign do_relay = fresh && (r_hop_limit != '0) && !terminal;
    assign ring_wr  = i_cmd.commit && fresh;

    always_comb begin
        n_coord_addr  = r_coord_addr;
        n_coord_known = r_coord_known;
        n_pong_flag   = r_pong_flag;
        if (raw_pong) begin
            n_pong_flag  = 1'b1;
            n_coord_addr = r_sender;
        end else if (learn) begin
            n_coord_addr  = r_origin;
            n_coord_known = 1'b1;
        end
    end

    assign scan_last = (r_cnt == mfrf_pkg::IDX_W'(mfrf_pkg::SEEN_DEPTH - 1));
    assign cnt_inc   = scan_last ? '0 : r_cnt + 1'b1;
    assign ptr_inc   = (r_ptr == mfrf_pkg::IDX_W'(mfrf_pkg::SEEN_DEPTH - 1)) ? '0 : r_ptr + 1'b1;

    assign o_status.is_mesh   = is_mesh;
    assign o_status.scan_last = scan_last;
    assign o_status.out_free  = !r_out_valid || i_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_role      <= 1'b0;
            r_own       <= '0;
            r_bcast     <= mfrf_pkg::RST_BCAST;
            r_code_data <= mfrf_pkg::RST_CODE_DATA;
            r_code_ping <= mfrf_pkg::RST_CODE_PING;
            r_code_pong <= mfrf_pkg::RST_CODE_PONG;
            r_hdr_bytes <= mfrf_pkg::RST_HDR_BYTES;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mfrf_pkg::CFG_NODE_ROLE:  r_role      <= i_cfg_data[0];
                mfrf_pkg::CFG_OWN_ADDR:   r_own       <= i_cfg_data;
                mfrf_pkg::CFG_BCAST_ADDR: r_bcast     <= i_cfg_data;
                mfrf_pkg::CFG_CODE_DATA:  r_code_data <= i_cfg_data[mfrf_pkg::BYTE_W-1:0];
                mfrf_pkg::CFG_CODE_PING:  r_code_ping <= i_cfg_data[mfrf_pkg::BYTE_W-1:0];
                mfrf_pkg::CFG_CODE_PONG:  r_code_pong <= i_cfg_data[mfrf_pkg::BYTE_W-1:0];
                mfrf_pkg::CFG_HDR_BYTES:  r_hdr_bytes <= i_cfg_data[mfrf_pkg::BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_frame_len <= i_frame_len;
            r_head_word <= i_head_word;
            r_sender    <= i_sender_address;
            r_msg_id    <= i_msg_id;
            r_pkt_type  <= i_pkt_type;
            r_hop_limit <= i_hop_limit;
            r_dest      <= i_dest_address;
            r_origin    <= i_origin_address;
            r_app_code  <= i_app_code;
            r_body_len  <= i_body_len;
        end
    end

    // ring memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (ring_wr) begin
            r_mem[r_ptr] <= {r_msg_id, r_pkt_type};
        end
        if (i_cmd.scan_step) begin
            r_rd_data <= r_mem[r_cnt];
            r_rd_vld  <= r_vld[r_cnt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld         <= '0;
            r_ptr         <= '0;
            r_cnt         <= '0;
            r_rd_live     <= 1'b0;
            r_hit         <= 1'b0;
            r_coord_addr  <= '0;
            r_coord_known <= 1'b0;
            r_pong_flag   <= 1'b0;
        end else begin
            r_rd_live <= i_cmd.scan_step;
            if (i_cmd.scan_start) begin
                r_cnt <= '0;
                r_hit <= 1'b0;
            end else begin
                if (i_cmd.scan_step) begin
                    r_cnt <= cnt_inc;
                end
                if (match) begin
                    r_hit <= 1'b1;
                end
            end
            if (ring_wr) begin
                r_vld[r_ptr] <= 1'b1;
                r_ptr        <= ptr_inc;
            end
            if (i_cmd.commit) begin
                r_coord_addr  <= n_coord_addr;
                r_coord_known <= n_coord_known;
                r_pong_flag   <= n_pong_flag;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_raw_pong_send <= raw_ping && r_role;
            o_reply_pong    <= fresh && is_ping;
            o_reply_app     <= (fresh && is_ping && r_role) ? mfrf_pkg::APP_COORD
                                                            : mfrf_pkg::APP_NODE;
            o_reply_dest    <= (fresh && is_ping) ? r_origin : '0;
            o_reply_hops    <= (fresh && is_ping) ? r_hop_limit : '0;
            o_deliver       <= fresh && ((is_ping && r_role && (r_body_len != '0))
                                         || (for_me && !is_ping));
            o_relay         <= do_relay;
            o_relay_hops    <= do_relay ? r_hop_limit - 1'b1 : '0;
            o_coord_address <= n_coord_addr;
            o_coord_known   <= n_coord_known;
            o_raw_pong_seen <= n_pong_flag;
            o_duplicate     <= is_mesh && r_hit;
        end
    end

    assign o_valid = r_out_valid;

endmodule

@@ design/mesh_flood_relay_filter_unit.sv @@
// channel   | handshake                  | payload
// ----------+----------------------------+---------------------------------------
// input     | i_valid / o_ready          | i_frame_len .. i_body_len
// result    | o_valid / i_ready          | o_raw_pong_send .. o_duplicate
// config    | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// raw frames and short frames: the item goes from idle through class to commit,
// and the result register loads in commit; the next item is taken in idle
// a mesh packet goes from class through scan and drain to commit: in scan the
// seen ring is read one entry per cycle through its single read port and
// compared, and drain compares the last read
// one item is in work at a time; the result register lets the next item in
// while the last result waits for i_ready, a second result waits in commit
// synchronous active-low reset empties the seen ring through its valid bits
module mesh_flood_relay_filter_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [mfrf_pkg::BYTE_W-1:0]    i_frame_len,
    input  logic [31:0]                    i_head_word,
    input  logic [mfrf_pkg::ADDR_W-1:0]    i_sender_address,
    input  logic [mfrf_pkg::ID_W-1:0]      i_msg_id,
    input  logic [mfrf_pkg::BYTE_W-1:0]    i_pkt_type,
    input  logic [mfrf_pkg::BYTE_W-1:0]    i_hop_limit,
    input  logic [mfrf_pkg::ADDR_W-1:0]    i_dest_address,
    input  logic [mfrf_pkg::ADDR_W-1:0]    i_origin_address,
    input  logic [mfrf_pkg::BYTE_W-1:0]    i_app_code,
    input  logic [mfrf_pkg::BYTE_W-1:0]    i_body_len,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_raw_pong_send,
    output logic                           o_reply_pong,
    output logic [mfrf_pkg::BYTE_W-1:0]    o_reply_app,
    output logic [mfrf_pkg::ADDR_W-1:0]    o_reply_dest,
    output logic [mfrf_pkg::BYTE_W-1:0]    o_reply_hops,
    output logic                           o_deliver,
    output logic                           o_relay,
    output logic [mfrf_pkg::BYTE_W-1:0]    o_relay_hops,
    output logic [mfrf_pkg::ADDR_W-1:0]    o_coord_address,
    output logic                           o_coord_known,
    output logic                           o_raw_pong_seen,
    output logic                           o_duplicate,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mfrf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mfrf_pkg::ADDR_W-1:0]    i_cfg_data
);

    mfrf_pkg::t_cmd    cmd;
    mfrf_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    mfrf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    mfrf_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_frame_len      (i_frame_len),
        .i_head_word      (i_head_word),
        .i_sender_address (i_sender_address),
        .i_msg_id         (i_msg_id),
        .i_pkt_type       (i_pkt_type),
        .i_hop_limit      (i_hop_limit),
        .i_dest_address   (i_dest_address),
        .i_origin_address (i_origin_address),
        .i_app_code       (i_app_code),
        .i_body_len       (i_body_len),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_raw_pong_send  (o_raw_pong_send),
        .o_reply_pong     (o_reply_pong),
        .o_reply_app      (o_reply_app),
        .o_reply_dest     (o_reply_dest),
        .o_reply_hops     (o_reply_hops),
        .o_deliver        (o_deliver),
        .o_relay          (o_relay),
        .o_relay_hops     (o_relay_hops),
        .o_coord_address  (o_coord_address),
        .o_coord_known    (o_coord_known),
        .o_raw_pong_seen  (o_raw_pong_seen),
        .o_duplicate      (o_duplicate)
    );

endmodule

@@ bench/tb.sv @@
module tb;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 215;
    localparam int RECENT_MAX  = 48;
    localparam logic [mfrf_pkg::ADDR_W-1:0] ALL_ONES   = 48'hFFFF_FFFF_FFFF;
    localparam logic [mfrf_pkg::ADDR_W-1:0] LOCAL_ADDR = 48'h0000_00AB_CDEF;

    typedef struct packed {
        logic [mfrf_pkg::BYTE_W-1:0] frame_len;
        logic [31:0]                 head_word;
        logic [mfrf_pkg::ADDR_W-1:0] sender_address;
        logic [mfrf_pkg::ID_W-1:0]   msg_id;
        logic [mfrf_pkg::BYTE_W-1:0] pkt_type;
        logic [mfrf_pkg::BYTE_W-1:0] hop_limit;
        logic [mfrf_pkg::ADDR_W-1:0] dest_address;
        logic [mfrf_pkg::ADDR_W-1:0] origin_address;
        logic [mfrf_pkg::BYTE_W-1:0] app_code;
        logic [mfrf_pkg::BYTE_W-1:0] body_len;
    } t_rx_frame;

    typedef struct packed {
        logic                        raw_pong_send;
        logic                        reply_pong;
        logic [mfrf_pkg::BYTE_W-1:0] reply_app;
        logic [mfrf_pkg::ADDR_W-1:0] reply_dest;
        logic [mfrf_pkg::BYTE_W-1:0] reply_hops;
        logic                        deliver;
        logic                        relay;
        logic [mfrf_pkg::BYTE_W-1:0] relay_hops;
        logic [mfrf_pkg::ADDR_W-1:0] coord_address;
        logic                        coord_known;
        logic                        raw_pong_seen;
        logic                        duplicate;
    } t_decision;

    typedef struct packed {
        logic [mfrf_pkg::ID_W-1:0]   id;
        logic [mfrf_pkg::BYTE_W-1:0] kind;
    } t_seen_pair;

    class flood_decision_board;
        logic                        role;
        logic [mfrf_pkg::ADDR_W-1:0] own_addr;
        logic [mfrf_pkg::ADDR_W-1:0] bcast_addr;
        logic [mfrf_pkg::BYTE_W-1:0] code_data;
        logic [mfrf_pkg::BYTE_W-1:0] code_ping;
        logic [mfrf_pkg::BYTE_W-1:0] code_pong;
        logic [mfrf_pkg::BYTE_W-1:0] hdr_bytes;

        bit                          ring_live [mfrf_pkg::SEEN_DEPTH];
        logic [mfrf_pkg::ID_W-1:0]   ring_id   [mfrf_pkg::SEEN_DEPTH];
        logic [mfrf_pkg::BYTE_W-1:0] ring_kind [mfrf_pkg::SEEN_DEPTH];
        int unsigned                 ring_wr;
        logic [mfrf_pkg::ADDR_W-1:0] coord_addr;
        bit                          coord_known;
        bit                          pong_heard;

        t_decision pending_decisions[$];
        int fails, n_frames, n_dup, n_relay, n_deliver, n_reply;

        function new();
            role       = 1'b0;
            own_addr   = '0;
            bcast_addr = mfrf_pkg::RST_BCAST;
            code_data  = mfrf_pkg::RST_CODE_DATA;
            code_ping  = mfrf_pkg::RST_CODE_PING;
            code_pong  = mfrf_pkg::RST_CODE_PONG;
            hdr_bytes  = mfrf_pkg::RST_HDR_BYTES;
            for (int k = 0; k < mfrf_pkg::SEEN_DEPTH; k++) begin
                ring_live[k] = 1'b0;
                ring_id[k]   = '0;
                ring_kind[k] = '0;
            end
            ring_wr     = 0;
            coord_addr  = '0;
            coord_known = 1'b0;
            pong_heard  = 1'b0;
            fails = 0;
            n_frames = 0;
            n_dup = 0;
            n_relay = 0;
            n_deliver = 0;
            n_reply = 0;
        endfunction

        function void write_reg(mfrf_pkg::t_cfg_idx idx, logic [mfrf_pkg::ADDR_W-1:0] val);
            case (idx)
                mfrf_pkg::CFG_NODE_ROLE:  role       = val[0];
                mfrf_pkg::CFG_OWN_ADDR:   own_addr   = val;
                mfrf_pkg::CFG_BCAST_ADDR: bcast_addr = val;
                mfrf_pkg::CFG_CODE_DATA:  code_data  = val[mfrf_pkg::BYTE_W-1:0];
                mfrf_pkg::CFG_CODE_PING:  code_ping  = val[mfrf_pkg::BYTE_W-1:0];
                mfrf_pkg::CFG_CODE_PONG:  code_pong  = val[mfrf_pkg::BYTE_W-1:0];
                mfrf_pkg::CFG_HDR_BYTES:  hdr_bytes  = val[mfrf_pkg::BYTE_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_frame(t_rx_frame f);
            t_decision d;
            bit hit, to_me, for_me, terminal;
            d = '0;
            n_frames++;
            if (f.frame_len == mfrf_pkg::RAW_LEN && f.head_word == mfrf_pkg::RAW_PING) begin
                if (role) d.raw_pong_send = 1'b1;
            end else if (f.frame_len == mfrf_pkg::RAW_LEN
                         && f.head_word == mfrf_pkg::RAW_PONG) begin
                pong_heard = 1'b1;
                coord_addr = f.sender_address;
            end else if (f.frame_len >= hdr_bytes) begin
                hit = 1'b0;
                for (int k = 0; k < mfrf_pkg::SEEN_DEPTH; k++)
                    if (ring_live[k] && ring_id[k] == f.msg_id && ring_kind[k] == f.pkt_type)
                        hit = 1'b1;
                if (hit) begin
                    d.duplicate = 1'b1;
                end else begin
                    to_me    = (f.dest_address == own_addr);
                    for_me   = to_me || (f.dest_address == bcast_addr);
                    terminal = (f.pkt_type == code_data) && to_me;
                    ring_live[ring_wr] = 1'b1;
                    ring_id[ring_wr]   = f.msg_id;
                    ring_kind[ring_wr] = f.pkt_type;
                    ring_wr = (ring_wr + 1) % mfrf_pkg::SEEN_DEPTH;
                    // each type code is tested on its own, even when codes are equal
                    if (f.pkt_type == code_ping) begin
                        d.reply_pong = 1'b1;
                        d.reply_app  = role ? mfrf_pkg::APP_COORD : mfrf_pkg::APP_NODE;
                        d.reply_dest = f.origin_address;
                        d.reply_hops = f.hop_limit;
                        if (role && f.body_len != 0) d.deliver = 1'b1;
                    end
                    if (!role && f.pkt_type == code_pong
                        && f.app_code == mfrf_pkg::APP_COORD) begin
                        coord_addr  = f.origin_address;
                        coord_known = 1'b1;
                    end
                    if (for_me && f.pkt_type != code_ping) d.deliver = 1'b1;
                    if (f.hop_limit != 0 && !terminal) begin
                        d.relay      = 1'b1;
                        d.relay_hops = f.hop_limit - 8'd1;
                    end
                end
            end
            d.coord_address = coord_addr;
            d.coord_known   = coord_known;
            d.raw_pong_seen = pong_heard;
            n_dup     += int'(d.duplicate);
            n_relay   += int'(d.relay);
            n_deliver += int'(d.deliver);
            n_reply   += int'(d.reply_pong);
            pending_decisions.push_back(d);
        endfunction

        function void same(string name, logic [mfrf_pkg::ADDR_W-1:0] want,
                           logic [mfrf_pkg::ADDR_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                fails++;
            end
        endfunction

        function void check_decision(t_decision got);
            t_decision want;
            if (pending_decisions.size() == 0) begin
                $error("decision item with no frame waiting for it");
                fails++;
                return;
            end
            want = pending_decisions.pop_front();
            same("raw_pong_send", 48'(want.raw_pong_send), 48'(got.raw_pong_send));
            same("reply_pong",    48'(want.reply_pong),    48'(got.reply_pong));
            same("reply_app",     48'(want.reply_app),     48'(got.reply_app));
            same("reply_dest",    want.reply_dest,         got.reply_dest);
            same("reply_hops",    48'(want.reply_hops),    48'(got.reply_hops));
            same("deliver",       48'(want.deliver),       48'(got.deliver));
            same("relay",         48'(want.relay),         48'(got.relay));
            same("relay_hops",    48'(want.relay_hops),    48'(got.relay_hops));
            same("coord_address", want.coord_address,      got.coord_address);
            same("coord_known",   48'(want.coord_known),   48'(got.coord_known));
            same("raw_pong_seen", 48'(want.raw_pong_seen), 48'(got.raw_pong_seen));
            same("duplicate",     48'(want.duplicate),     48'(got.duplicate));
        endfunction

        function int pending();
            return pending_decisions.size();
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_ready;
    logic [mfrf_pkg::BYTE_W-1:0]     i_frame_len = '0;
    logic [31:0]                     i_head_word = '0;
    logic [mfrf_pkg::ADDR_W-1:0]     i_sender_address = '0;
    logic [mfrf_pkg::ID_W-1:0]       i_msg_id = '0;
    logic [mfrf_pkg::BYTE_W-1:0]     i_pkt_type = '0;
    logic [mfrf_pkg::BYTE_W-1:0]     i_hop_limit = '0;
    logic [mfrf_pkg::ADDR_W-1:0]     i_dest_address = '0;
    logic [mfrf_pkg::ADDR_W-1:0]     i_origin_address = '0;
    logic [mfrf_pkg::BYTE_W-1:0]     i_app_code = '0;
    logic [mfrf_pkg::BYTE_W-1:0]     i_body_len = '0;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    logic                            o_raw_pong_send;
    logic                            o_reply_pong;
    logic [mfrf_pkg::BYTE_W-1:0]     o_reply_app;
    logic [mfrf_pkg::ADDR_W-1:0]     o_reply_dest;
    logic [mfrf_pkg::BYTE_W-1:0]     o_reply_hops;
    logic                            o_deliver;
    logic                            o_relay;
    logic [mfrf_pkg::BYTE_W-1:0]     o_relay_hops;
    logic [mfrf_pkg::ADDR_W-1:0]     o_coord_address;
    logic                            o_coord_known;
    logic                            o_raw_pong_seen;
    logic                            o_duplicate;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [mfrf_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [mfrf_pkg::ADDR_W-1:0]     i_cfg_data = '0;

    mesh_flood_relay_filter_unit dut (.*);

    flood_decision_board sb = new();
    t_seen_pair recent[$];
    bit quiet = 1'b0;
    bit rx_hold_req = 1'b0;
    int settings_used = 0;
    int idle_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [mfrf_pkg::ADDR_W-1:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[mfrf_pkg::ADDR_W-1:0];
    endfunction

    // random junk outside the bits that the register keeps
    function automatic logic [mfrf_pkg::ADDR_W-1:0] with_junk(
        input logic [mfrf_pkg::ADDR_W-1:0] low, input logic [mfrf_pkg::ADDR_W-1:0] keep);
        return (rand48() & ~keep) | (low & keep);
    endfunction

    function automatic t_rx_frame mk(logic [7:0] len, logic [31:0] head, logic [47:0] snd,
                                     logic [31:0] id, logic [7:0] kind, logic [7:0] hops,
                                     logic [47:0] dst, logic [47:0] org, logic [7:0] app,
                                     logic [7:0] body);
        return {len, head, snd, id, kind, hops, dst, org, app, body};
    endfunction

    function automatic t_rx_frame gen_frame();
        t_rx_frame f;
        t_seen_pair p;
        int pick;
        f.frame_len      = 8'($urandom_range(250));
        f.head_word      = $urandom;
        f.sender_address = rand48();
        f.msg_id         = $urandom;
        f.pkt_type       = 8'($urandom_range(255));
        f.hop_limit      = 8'($urandom_range(255));
        f.dest_address   = rand48();
        f.origin_address = rand48();
        f.app_code       = 8'($urandom_range(255));
        f.body_len       = 8'($urandom_range(200));
        pick = $urandom_range(99);
        if (pick < 7) begin
            f.frame_len = mfrf_pkg::RAW_LEN;
            f.head_word = mfrf_pkg::RAW_PING;
        end else if (pick < 13) begin
            f.frame_len = mfrf_pkg::RAW_LEN;
            f.head_word = mfrf_pkg::RAW_PONG;
        end else if (pick < 20) begin
            // runts, half of them 4 bytes with a stray head word
            if ($urandom_range(1)) f.frame_len = mfrf_pkg::RAW_LEN;
            else f.frame_len = 8'($urandom_range(sb.hdr_bytes - 1));
        end else begin
            f.frame_len = 8'($urandom_range(250, sb.hdr_bytes));
            if (recent.size() > 0 && $urandom_range(99) < 40) begin
                // replay a recent pair, often still held in the ring
                p = recent[$urandom_range(recent.size() - 1)];
                f.msg_id   = p.id;
                f.pkt_type = p.kind;
            end else begin
                case ($urandom_range(4))
                    0: f.pkt_type = sb.code_data;
                    1: f.pkt_type = sb.code_ping;
                    2: f.pkt_type = sb.code_pong;
                    default: ;
                endcase
                p.id   = f.msg_id;
                p.kind = f.pkt_type;
                recent.push_back(p);
                if (recent.size() > RECENT_MAX) void'(recent.pop_front());
            end
            case ($urandom_range(3))
                0: f.dest_address = sb.own_addr;
                1: f.dest_address = sb.bcast_addr;
                default: ;
            endcase
            if (f.pkt_type == sb.code_pong && $urandom_range(1))
                f.app_code = mfrf_pkg::APP_COORD;
            case ($urandom_range(9))
                0: f.hop_limit = 8'd0;
                1: f.hop_limit = 8'hFF;
                2: f.hop_limit = 8'd1;
                default: ;
            endcase
            if ($urandom_range(3) == 0) f.body_len = 8'd0;
        end
        return f;
    endfunction

    task automatic send_item(input t_rx_frame f);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(99) < 30) gap = $urandom_range(45, 1);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_frame_len      <= f.frame_len;
        i_head_word      <= f.head_word;
        i_sender_address <= f.sender_address;
        i_msg_id         <= f.msg_id;
        i_pkt_type       <= f.pkt_type;
        i_hop_limit      <= f.hop_limit;
        i_dest_address   <= f.dest_address;
        i_origin_address <= f.origin_address;
        i_app_code       <= f.app_code;
        i_body_len       <= f.body_len;
        do @(posedge i_clk); while (!o_ready);
        sb.note_frame(f);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic cfg_write(input mfrf_pkg::t_cfg_idx idx,
                             input logic [mfrf_pkg::ADDR_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
    endtask

    // narrow registers get junk in the unused upper data bits
    task automatic load_settings(input logic role, input logic [47:0] own,
                                 input logic [47:0] bcast, input logic [7:0] cd,
                                 input logic [7:0] cp, input logic [7:0] cq,
                                 input logic [7:0] hdr);
        cfg_write(mfrf_pkg::CFG_NODE_ROLE,  with_junk({47'b0, role}, 48'h1));
        cfg_write(mfrf_pkg::CFG_OWN_ADDR,   own);
        cfg_write(mfrf_pkg::CFG_BCAST_ADDR, bcast);
        cfg_write(mfrf_pkg::CFG_CODE_DATA,  with_junk({40'b0, cd}, 48'hFF));
        cfg_write(mfrf_pkg::CFG_CODE_PING,  with_junk({40'b0, cp}, 48'hFF));
        cfg_write(mfrf_pkg::CFG_CODE_PONG,  with_junk({40'b0, cq}, 48'hFF));
        cfg_write(mfrf_pkg::CFG_HDR_BYTES,  with_junk({40'b0, hdr}, 48'hFF));
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic run_phase(input int n, input bit hold);
        for (int i = 0; i < n; i++) begin
            if (hold && i == 40) rx_hold_req = 1'b1;
            send_item(gen_frame());
        end
        wait_drained();
    endtask

    // result side
    initial begin
        int hold_left;
        t_decision got;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                got = {o_raw_pong_send, o_reply_pong, o_reply_app, o_reply_dest, o_reply_hops,
                       o_deliver, o_relay, o_relay_hops, o_coord_address, o_coord_known,
                       o_raw_pong_seen, o_duplicate};
                sb.check_decision(got);
            end
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 30);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        int bad;
        logic [7:0] c0, c1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: plain node, header 220
        send_item(mk(mfrf_pkg::RAW_LEN, mfrf_pkg::RAW_PING, 48'h0000_1111_2222,
                     '0, '0, '0, '0, '0, '0, '0));
        send_item(mk(mfrf_pkg::RAW_LEN, mfrf_pkg::RAW_PONG, 48'hA5A5_0102_0304,
                     '0, '0, '0, '0, '0, '0, '0));
        send_item(mk(mfrf_pkg::RAW_LEN, 32'hDEAD_BEEF, 48'h5, 32'h9, 8'd1, 8'd3,
                     '0, '0, '0, '0));
        send_item(mk(8'd219, '0, '0, 32'h11, 8'd1, 8'd3, '0, '0, '0, '0));
        send_item(mk('0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        send_item(mk(8'd220, 32'hFFFF_FFFF, 48'h1, 32'h1, 8'd1, 8'd5, '0,
                     48'h7777_0000_0001, '0, 8'd10));
        send_item(mk(8'd220, 32'hFFFF_FFFF, 48'h1, 32'h1, 8'd1, 8'd5, '0,
                     48'h7777_0000_0001, '0, 8'd10));
        send_item(mk(8'd220, '0, 48'h1, 32'h1, 8'd2, 8'd7, 48'h1234,
                     48'h7777_0000_0002, '0, '0));
        send_item(mk(8'd250, '0, 48'h2, 32'h2, 8'd3, '0, ALL_ONES, 48'hC0DE_0000_0009,
                     mfrf_pkg::APP_COORD, 8'd4));
        send_item(mk(8'd230, '0, 48'h3, 32'h3, 8'd1, 8'hFF, ALL_ONES, 48'h5, '0, 8'd200));
        send_item(mk(8'd221, '0, 48'h4, 32'h4, 8'd1, 8'd1, 48'h9999, 48'h6, '0, 8'd1));
        send_item(mk(8'd250, 32'hFFFF_FFFF, ALL_ONES, 32'hFFFF_FFFF, 8'hFF, 8'hFF, ALL_ONES,
                     ALL_ONES, 8'hFF, 8'd200));
        send_item(mk(mfrf_pkg::RAW_LEN, mfrf_pkg::RAW_PONG, 48'h0BAD_CAFE_0001,
                     '0, '0, '0, '0, '0, '0, '0));
        wait_drained();

        // coordinator, shortest header, broadcast at zero
        load_settings(1'b1, LOCAL_ADDR, '0, 8'd1, 8'd2, 8'd3, 8'd5);
        send_item(mk(mfrf_pkg::RAW_LEN, mfrf_pkg::RAW_PING, 48'h42,
                     '0, '0, '0, '0, '0, '0, '0));
        send_item(mk(8'd5, '0, '0, 32'h10, 8'd2, 8'd9, LOCAL_ADDR, 48'h31, '0, '0));
        send_item(mk(8'd5, '0, '0, 32'h11, 8'd2, '0, '0, 48'h32, '0, 8'd200));
        send_item(mk(8'd6, '0, '0, 32'h12, 8'd3, 8'd2, 48'h55, 48'h33,
                     mfrf_pkg::APP_COORD, '0));
        send_item(mk(8'd5, '0, '0, 32'h13, 8'd1, 8'd4, LOCAL_ADDR, 48'h34, '0, 8'd3));
        send_item(mk(mfrf_pkg::RAW_LEN, 32'h504F_4E46, '0, 32'h15, 8'd1, 8'd1,
                     '0, '0, '0, '0));
        send_item(mk(8'd5, '0, '0, 32'h14, 8'd1, 8'd2, '0, 48'h35, '0, 8'd1));
        send_item(mk(8'd5, '0, '0, 32'h13, 8'd1, 8'd4, LOCAL_ADDR, 48'h34, '0, 8'd3));
        wait_drained();

        load_settings(1'b0, rand48(), ALL_ONES, 8'd1, 8'd2, 8'd3, 8'd220);
        run_phase(PHASE_ITEMS, 1'b0);

        load_settings(1'b1, ALL_ONES, '0, 8'h00, 8'hFF, 8'h80, 8'd250);
        run_phase(PHASE_ITEMS, 1'b1);

        c0 = 8'($urandom_range(255));
        load_settings(1'b0, '0, rand48(), c0, c0, c0, 8'd5);
        run_phase(PHASE_ITEMS, 1'b0);

        c0 = 8'($urandom_range(255));
        c1 = c0 + 8'd1;
        quiet = 1'b1;
        load_settings(1'b1, rand48(), rand48(), c0, c0, c1, 8'($urandom_range(250, 5)));
        run_phase(PHASE_ITEMS, 1'b0);
        quiet = 1'b0;

        c0 = 8'($urandom_range(255));
        c1 = c0 ^ 8'h5A;
        load_settings(1'b0, rand48(), ALL_ONES, c0, c1, c0, 8'd5);
        run_phase(PHASE_ITEMS, 1'b0);

        load_settings(1'b1, rand48(), rand48(), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(250, 5)));
        run_phase(PHASE_ITEMS, 1'b0);

        repeat (50) @(posedge i_clk);
        bad = sb.fails + sb.pending();
        $display("ran %0d frames under %0d register settings", sb.n_frames, settings_used + 1);
        $display("decisions: %0d duplicates, %0d relays, %0d deliveries, %0d pong replies",
                 sb.n_dup, sb.n_relay, sb.n_deliver, sb.n_reply);
        if (bad == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

@@ filelist.f @@
design/mfrf_pkg.sv
design/mfrf_ctrl.sv
design/mfrf_dp.sv
design/mesh_flood_relay_filter_unit.sv
bench/tb.sv
